@@ rtl/tphe_pkg.sv @@
// tphe_pkg: shared types, fixed field widths, fixed-point constants and helper
// functions for the turtle position and heading engine
// depends on nothing; used by the channel interfaces and the top level
package tphe_pkg;

    // port field widths
    localparam int OP_W   = 4;
    localparam int VAL_W  = 24;
    localparam int POS_W  = 24;
    localparam int HDG_W  = 18;
    localparam int SCR_W  = 16;
    localparam int KIND_W = 2;
    localparam int ORG_W  = 12;
    localparam int ASP_W  = 16;
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    // datapath widths
    localparam int H_W       = 26;            // heading in degrees q.16, folded to [0,360)
    localparam int Z_W       = 25;            // cordic residual angle
    localparam int CX_W      = 33;            // cordic vector, q.30
    localparam int MA_W      = 26;            // multiplier operand a
    localparam int MB_W      = 33;            // multiplier operand b
    localparam int P_W       = MA_W + MB_W;   // product
    localparam int RND_W     = 28;            // rounded product
    localparam int YS_W      = RND_W + 1;     // position plus step
    localparam int SCR_SUM_W = 26;            // origin plus rounded pixel

    localparam int POS_MAX = 8388607;
    localparam int POS_MIN = -8388608;
    localparam int SCR_MAX = 32767;
    localparam int SCR_MIN = -32768;

    localparam int DEG16     = 65536;
    localparam int CORDIC_K  = 652032874;
    localparam int ATAN_N    = 24;
    localparam int TRIG_SHIFT = 30;
    localparam int ASP_SHIFT  = 14;

    localparam logic signed [H_W-1:0] DEG_45  = H_W'(45 * DEG16);
    localparam logic signed [H_W-1:0] DEG_90  = H_W'(90 * DEG16);
    localparam logic signed [H_W-1:0] DEG_135 = H_W'(135 * DEG16);
    localparam logic signed [H_W-1:0] DEG_180 = H_W'(180 * DEG16);
    localparam logic signed [H_W-1:0] DEG_225 = H_W'(225 * DEG16);
    localparam logic signed [H_W-1:0] DEG_270 = H_W'(270 * DEG16);
    localparam logic signed [H_W-1:0] DEG_315 = H_W'(315 * DEG16);
    localparam logic signed [H_W-1:0] DEG_360 = H_W'(360 * DEG16);

    localparam logic signed [P_W-1:0] HALF_TRIG = P_W'(1) <<< (TRIG_SHIFT - 1);
    localparam logic signed [P_W-1:0] HALF_ASP  = P_W'(1) <<< (ASP_SHIFT - 1);

    typedef enum logic [OP_W-1:0] {
        OP_FWD     = 4'd0,
        OP_RIGHT   = 4'd1,
        OP_LEFT    = 4'd2,
        OP_SETHDG  = 4'd3,
        OP_SETPOS  = 4'd4,
        OP_SETX    = 4'd5,
        OP_SETY    = 4'd6,
        OP_HOME    = 4'd7,
        OP_PENUP   = 4'd8,
        OP_PENDOWN = 4'd9
    } t_op;

    typedef enum logic [KIND_W-1:0] {
        KIND_NONE = 2'd0,
        KIND_MOVE = 2'd1,
        KIND_LINE = 2'd2
    } t_draw_kind;

    typedef enum logic [1:0] {
        REG_ORIGIN_COL = 2'd0,
        REG_ORIGIN_ROW = 2'd1,
        REG_SCRUNCH    = 2'd2,
        REG_ASPECT     = 2'd3
    } t_reg_idx;

    // arctangent of 2^-i in degrees q.16
    function automatic logic [21:0] atan_deg16(input logic [4:0] idx);
        logic [21:0] v;
        unique case (idx)
            5'd0:    v = 22'd2949120;
            5'd1:    v = 22'd1740967;
            5'd2:    v = 22'd919879;
            5'd3:    v = 22'd466945;
            5'd4:    v = 22'd234379;
            5'd5:    v = 22'd117304;
            5'd6:    v = 22'd58666;
            5'd7:    v = 22'd29335;
            5'd8:    v = 22'd14668;
            5'd9:    v = 22'd7334;
            5'd10:   v = 22'd3667;
            5'd11:   v = 22'd1833;
            5'd12:   v = 22'd917;
            5'd13:   v = 22'd458;
            5'd14:   v = 22'd229;
            5'd15:   v = 22'd115;
            5'd16:   v = 22'd57;
            5'd17:   v = 22'd29;
            5'd18:   v = 22'd14;
            5'd19:   v = 22'd7;
            5'd20:   v = 22'd4;
            5'd21:   v = 22'd2;
            5'd22:   v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

    // clamp to the signed position range
    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [YS_W-1:0] v);
        logic signed [POS_W-1:0] r;
        if (v > YS_W'(POS_MAX)) begin
            r = POS_W'(POS_MAX);
        end else if (v < YS_W'(POS_MIN)) begin
            r = POS_W'(POS_MIN);
        end else begin
            r = POS_W'(v);
        end
        return r;
    endfunction

    // clamp to the signed screen range
    function automatic logic signed [SCR_W-1:0] sat_scr(input logic signed [SCR_SUM_W-1:0] v);
        logic signed [SCR_W-1:0] r;
        if (v > SCR_SUM_W'(SCR_MAX)) begin
            r = SCR_W'(SCR_MAX);
        end else if (v < SCR_SUM_W'(SCR_MIN)) begin
            r = SCR_W'(SCR_MIN);
        end else begin
            r = SCR_W'(v);
        end
        return r;
    endfunction

endpackage

@@ rtl/tphe_if.sv @@
// tphe_if: valid/ready channel interfaces for turtle commands and results
// depends on tphe_pkg for the field widths
interface tphe_cmd_if;
    logic                                  valid;
    logic                                  ready;
    logic [tphe_pkg::OP_W-1:0]             op;
    logic signed [tphe_pkg::VAL_W-1:0]     value_a;
    logic signed [tphe_pkg::VAL_W-1:0]     value_b;

    modport source (output valid, output op, output value_a, output value_b, input ready);
    modport sink   (input valid, input op, input value_a, input value_b, output ready);
endinterface

interface tphe_res_if;
    logic                                  valid;
    logic                                  ready;
    logic [tphe_pkg::KIND_W-1:0]           draw_kind;
    logic signed [tphe_pkg::SCR_W-1:0]     screen_col;
    logic signed [tphe_pkg::SCR_W-1:0]     screen_row;
    logic signed [tphe_pkg::POS_W-1:0]     pos_x;
    logic signed [tphe_pkg::POS_W-1:0]     pos_y;
    logic signed [tphe_pkg::HDG_W-1:0]     heading_deg;
    logic                                  pen_is_down;

    modport source (output valid, output draw_kind, output screen_col, output screen_row,
                    output pos_x, output pos_y, output heading_deg, output pen_is_down,
                    input ready);
    modport sink   (input valid, input draw_kind, input screen_col, input screen_row,
                    input pos_x, input pos_y, input heading_deg, input pen_is_down,
                    output ready);
endinterface

@@ rtl/turtle_position_heading_engine_unit.sv @@
// turtle_position_heading_engine_unit: turtle position, heading and pen state engine
// depends on tphe_pkg and the channel interfaces in tphe_if.sv
//
// steps, accept to result valid: forward runs decode, quadrant fold, cordic rotation,
// sine and cosine multiplies and rounding, plus the aspect multiply if scrunch is on;
// turns and set heading run decode and the modulo loop; set y or set position with
// scrunch run decode and the aspect multiply; all other commands only decode
// one command in flight; the result register frees the sequencer while a result waits
// reset (i_rst_n low, synchronous): position 0,0, heading north, pen down, origin 0,0,
// scrunch on, aspect ratio 1.0, no result pending
module turtle_position_heading_engine_unit #(
    parameter int CORDIC_STEPS = 16,
    parameter int FRAC_BITS    = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    tphe_cmd_if.sink                      i_cmd,
    tphe_res_if.source                    o_res,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tphe_pkg::APB_AW-1:0]   paddr,
    input  logic [tphe_pkg::APB_DW-1:0]   pwdata,
    output logic [tphe_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);
    import tphe_pkg::*;

    // derived sizes
    localparam int NSTEP     = (CORDIC_STEPS > ATAN_N) ? ATAN_N : CORDIC_STEPS;
    localparam int FULL_TURN = 360 << FRAC_BITS;
    localparam int HEAD_W    = $clog2(FULL_TURN) + 1;
    localparam int SUM_W     = ((HEAD_W > VAL_W) ? HEAD_W : VAL_W) + 1;
    localparam int FT_BITS   = $clog2(FULL_TURN + 1);
    localparam int MOD_STEPS = (SUM_W - FT_BITS > 1) ? (SUM_W - FT_BITS) : 1;
    localparam int CNT_A     = $clog2(NSTEP);
    localparam int CNT_B     = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;
    localparam int CNT_W     = (CNT_A > CNT_B) ? CNT_A : CNT_B;
    localparam int HSHIFT    = 16 - FRAC_BITS;
    localparam int PX_W      = POS_W + 1;

    localparam logic signed [PX_W-1:0]  PIX_HALF = PX_W'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [SUM_W-1:0] TURN_S   = SUM_W'(FULL_TURN);

    // sequencer states
    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_DECODE = 11'b000_0000_0010,
        S_MOD    = 11'b000_0000_0100,
        S_QUAD   = 11'b000_0000_1000,
        S_ROT    = 11'b000_0001_0000,
        S_MULS   = 11'b000_0010_0000,
        S_MULC   = 11'b000_0100_0000,
        S_RNDC   = 11'b000_1000_0000,
        S_MULY   = 11'b001_0000_0000,
        S_RNDY   = 11'b010_0000_0000,
        S_FIN    = 11'b100_0000_0000
    } t_state;

    t_state r_state, n_state;

    // configuration registers
    logic [ORG_W-1:0] r_origin_col, r_origin_row;
    logic             r_scrunch_on;
    logic [ASP_W-1:0] r_aspect_ratio;

    // turtle state
    logic signed [POS_W-1:0]  r_pos_x, r_pos_y;
    logic signed [HEAD_W-1:0] r_heading;
    logic                     r_pen;

    // latched command
    t_op                     r_op;
    logic signed [VAL_W-1:0] r_a, r_b;

    // working registers
    logic signed [SUM_W-1:0] r_rem;
    logic                    r_neg;
    logic signed [H_W-1:0]   r_h;
    logic [1:0]              r_q;
    logic signed [Z_W-1:0]   r_z;
    logic signed [CX_W-1:0]  r_cx, r_cy;
    logic [CNT_W-1:0]        r_cnt;
    logic signed [P_W-1:0]   r_prod;
    logic signed [RND_W-1:0] r_dx;
    logic signed [MA_W-1:0]  r_dy0;

    // result register
    logic                    r_out_valid, n_out_valid;
    t_draw_kind              r_out_kind;
    logic signed [SCR_W-1:0] r_out_col, r_out_row;
    logic signed [POS_W-1:0] r_out_x, r_out_y;
    logic signed [HDG_W-1:0] r_out_hdg;
    logic                    r_out_pen;

    // ---------------------------------------------------------------------
    // configuration port, write in the access phase, reads are plain muxes
    // ---------------------------------------------------------------------
    logic     cfg_wr;
    t_reg_idx cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = t_reg_idx'(paddr[3:2]);

    always_comb begin
        unique case (cfg_idx)
            REG_ORIGIN_COL: prdata = APB_DW'(r_origin_col);
            REG_ORIGIN_ROW: prdata = APB_DW'(r_origin_row);
            REG_SCRUNCH:    prdata = APB_DW'(r_scrunch_on);
            REG_ASPECT:     prdata = APB_DW'(r_aspect_ratio);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_col   <= '0;
            r_origin_row   <= '0;
            r_scrunch_on   <= 1'b1;
            r_aspect_ratio <= ASP_W'(16384);
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_ORIGIN_COL: r_origin_col   <= pwdata[ORG_W-1:0];
                REG_ORIGIN_ROW: r_origin_row   <= pwdata[ORG_W-1:0];
                REG_SCRUNCH:    r_scrunch_on   <= pwdata[0];
                REG_ASPECT:     r_aspect_ratio <= pwdata[ASP_W-1:0];
                default:        ;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // handshakes
    // ---------------------------------------------------------------------
    logic cmd_take, res_load;

    assign i_cmd.ready = (r_state == S_IDLE);
    assign cmd_take    = i_cmd.valid && i_cmd.ready;
    // the result register can be refilled in the cycle it drains
    assign res_load    = (r_state == S_FIN) && (!r_out_valid || o_res.ready);

    assign o_res.valid       = r_out_valid;
    assign o_res.draw_kind   = r_out_kind;
    assign o_res.screen_col  = r_out_col;
    assign o_res.screen_row  = r_out_row;
    assign o_res.pos_x       = r_out_x;
    assign o_res.pos_y       = r_out_y;
    assign o_res.heading_deg = r_out_hdg;
    assign o_res.pen_is_down = r_out_pen;

    // ---------------------------------------------------------------------
    // decode helpers: heading sum for turns, heading folded for sin/cos
    // ---------------------------------------------------------------------
    logic signed [SUM_W-1:0] dec_sum;
    logic signed [H_W-1:0]   dec_hsh, dec_hnorm;

    always_comb begin
        unique case (r_op)
            OP_RIGHT: dec_sum = SUM_W'(r_heading) + SUM_W'(r_a);
            OP_LEFT:  dec_sum = SUM_W'(r_heading) - SUM_W'(r_a);
            default:  dec_sum = SUM_W'(r_a);
        endcase
    end

    // heading is always inside the open full turn, so one correction folds it
    assign dec_hsh   = H_W'(r_heading) <<< HSHIFT;
    assign dec_hnorm = (dec_hsh < 0) ? (dec_hsh + DEG_360) : dec_hsh;

    // ---------------------------------------------------------------------
    // modulo unit: one shifted full turn is tried per cycle, keeping the
    // dividend's sign so the remainder truncates like a c remainder
    // ---------------------------------------------------------------------
    logic signed [SUM_W-1:0] mod_cmp, mod_next;
    logic signed [SUM_W:0]   mod_t;
    logic                    mod_take;

    assign mod_cmp  = TURN_S <<< r_cnt;
    assign mod_t    = r_neg ? ((SUM_W+1)'(r_rem) + (SUM_W+1)'(mod_cmp))
                            : ((SUM_W+1)'(r_rem) - (SUM_W+1)'(mod_cmp));
    assign mod_take = r_neg ? (mod_t <= 0) : (mod_t >= 0);
    assign mod_next = mod_take ? SUM_W'(mod_t) : r_rem;

    // ---------------------------------------------------------------------
    // quadrant fold: residual in [-45,45) and quadrant number
    // ---------------------------------------------------------------------
    logic [1:0]            quad_q;
    logic signed [H_W-1:0] quad_base, quad_z;

    always_comb begin
        priority if (r_h >= DEG_315) begin
            quad_q = 2'd0;
            quad_base = DEG_360;
        end else if (r_h >= DEG_225) begin
            quad_q = 2'd3;
            quad_base = DEG_270;
        end else if (r_h >= DEG_135) begin
            quad_q = 2'd2;
            quad_base = DEG_180;
        end else if (r_h >= DEG_45) begin
            quad_q = 2'd1;
            quad_base = DEG_90;
        end else begin
            quad_q = 2'd0;
            quad_base = '0;
        end
    end

    assign quad_z = r_h - quad_base;

    // ---------------------------------------------------------------------
    // cordic rotation unit, one step per cycle, shift set by the step count
    // ---------------------------------------------------------------------
    logic signed [CX_W-1:0] rot_xs, rot_ys, rot_x, rot_y;
    logic signed [Z_W-1:0]  rot_atan, rot_z;

    assign rot_xs   = r_cx >>> r_cnt;
    assign rot_ys   = r_cy >>> r_cnt;
    assign rot_atan = Z_W'(atan_deg16(5'(r_cnt)));

    always_comb begin
        if (r_z >= 0) begin
            rot_x = r_cx - rot_ys;
            rot_y = r_cy + rot_xs;
            rot_z = r_z - rot_atan;
        end else begin
            rot_x = r_cx + rot_ys;
            rot_y = r_cy - rot_xs;
            rot_z = r_z + rot_atan;
        end
    end

    // quadrant unfold to sine and cosine, q.30
    logic signed [CX_W-1:0] trig_s, trig_c;

    always_comb begin
        unique case (r_q)
            2'd0: begin
                trig_s = r_cy;
                trig_c = r_cx;
            end
            2'd1: begin
                trig_s = r_cx;
                trig_c = -r_cy;
            end
            2'd2: begin
                trig_s = -r_cy;
                trig_c = -r_cx;
            end
            default: begin
                trig_s = -r_cx;
                trig_c = r_cy;
            end
        endcase
    end

    // ---------------------------------------------------------------------
    // shared multiplier: distance by sine, distance by cosine, y by aspect
    // product is registered every cycle and consumed in the next state
    // ---------------------------------------------------------------------
    logic signed [MA_W-1:0] mul_a;
    logic signed [MB_W-1:0] mul_b;
    logic signed [P_W-1:0]  mul_p;

    always_comb begin
        unique case (r_state)
            S_MULS: begin
                mul_a = MA_W'(r_a);
                mul_b = MB_W'(trig_s);
            end
            S_MULC: begin
                mul_a = MA_W'(r_a);
                mul_b = MB_W'(trig_c);
            end
            default: begin
                mul_a = r_dy0;
                mul_b = MB_W'($signed({1'b0, r_aspect_ratio}));
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // shared rounding: halves away from zero, by 30 for trig, by 14 for aspect
    logic                    rnd_trig;
    logic signed [P_W-1:0]   rnd_adj, rnd_t;
    logic signed [RND_W-1:0] rnd_q;

    assign rnd_trig = (r_state == S_MULC) || (r_state == S_RNDC);
    assign rnd_adj  = (rnd_trig ? HALF_TRIG : HALF_ASP) - ((r_prod < 0) ? P_W'(1) : P_W'(0));
    assign rnd_t    = r_prod + rnd_adj;
    assign rnd_q    = rnd_trig ? RND_W'(rnd_t >>> TRIG_SHIFT) : RND_W'(rnd_t >>> ASP_SHIFT);

    // position updates for forward and direct y writes
    logic signed [POS_W-1:0] upd_x, upd_y_fwd, upd_y_asp;
    logic signed [YS_W-1:0]  y_base;

    assign upd_x     = sat_pos(YS_W'(r_pos_x) + YS_W'(r_dx));
    assign upd_y_fwd = sat_pos(YS_W'(r_pos_y) + YS_W'(rnd_q));
    // forward adds the scaled step, set y replaces the position
    assign y_base    = (r_op == OP_FWD) ? YS_W'(r_pos_y) : '0;
    assign upd_y_asp = sat_pos(y_base + YS_W'(rnd_q));

    // ---------------------------------------------------------------------
    // screen position from the turtle state
    // ---------------------------------------------------------------------
    logic signed [PX_W-1:0]      pix_xt, pix_yt, pix_x, pix_y;
    logic signed [SCR_SUM_W-1:0] scr_col, scr_row;
    t_draw_kind                  fin_kind;

    assign pix_xt  = PX_W'(r_pos_x) + ((r_pos_x < 0) ? (PIX_HALF - PX_W'(1)) : PIX_HALF);
    assign pix_yt  = PX_W'(r_pos_y) + ((r_pos_y < 0) ? (PIX_HALF - PX_W'(1)) : PIX_HALF);
    assign pix_x   = pix_xt >>> FRAC_BITS;
    assign pix_y   = pix_yt >>> FRAC_BITS;
    assign scr_col = SCR_SUM_W'($signed({1'b0, r_origin_col})) + SCR_SUM_W'(pix_x);
    assign scr_row = SCR_SUM_W'($signed({1'b0, r_origin_row})) - SCR_SUM_W'(pix_y);

    always_comb begin
        unique case (r_op)
            OP_FWD:    fin_kind = r_pen ? KIND_LINE : KIND_MOVE;
            OP_SETPOS,
            OP_SETX,
            OP_SETY,
            OP_HOME:   fin_kind = KIND_MOVE;
            default:   fin_kind = KIND_NONE;
        endcase
    end

    // ---------------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (cmd_take) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (r_op)
                    OP_FWD:    n_state = S_QUAD;
                    OP_RIGHT,
                    OP_LEFT,
                    OP_SETHDG: n_state = S_MOD;
                    OP_SETPOS,
                    OP_SETY:   n_state = r_scrunch_on ? S_MULY : S_FIN;
                    default:   n_state = S_FIN;
                endcase
            end
            S_MOD: begin
                if (r_cnt == '0) begin
                    n_state = S_FIN;
                end
            end
            S_QUAD: n_state = S_ROT;
            S_ROT: begin
                if (r_cnt == CNT_W'(NSTEP - 1)) begin
                    n_state = S_MULS;
                end
            end
            S_MULS: n_state = S_MULC;
            S_MULC: n_state = S_RNDC;
            S_RNDC: n_state = r_scrunch_on ? S_MULY : S_FIN;
            S_MULY: n_state = S_RNDY;
            S_RNDY: n_state = S_FIN;
            S_FIN: begin
                if (res_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (res_load) begin
            n_out_valid = 1'b1;
        end else if (o_res.ready) begin
            n_out_valid = 1'b0;
        end
    end

    // control and turtle state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_heading   <= '0;
            r_pen       <= 1'b1;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            unique case (r_state)
                S_DECODE: begin
                    unique case (r_op)
                        OP_SETPOS: begin
                            r_pos_x <= r_a;
                            if (!r_scrunch_on) begin
                                r_pos_y <= r_b;
                            end
                        end
                        OP_SETX: r_pos_x <= r_a;
                        OP_SETY: begin
                            if (!r_scrunch_on) begin
                                r_pos_y <= r_b;
                            end
                        end
                        OP_HOME: begin
                            r_pos_x   <= '0;
                            r_pos_y   <= '0;
                            r_heading <= '0;
                            r_pen     <= 1'b1;
                        end
                        OP_PENUP:   r_pen <= 1'b0;
                        OP_PENDOWN: r_pen <= 1'b1;
                        default:    ;
                    endcase
                end
                S_MOD: begin
                    if (r_cnt == '0) begin
                        r_heading <= HEAD_W'(mod_next);
                    end
                end
                S_RNDC: begin
                    r_pos_x <= upd_x;
                    if (!r_scrunch_on) begin
                        r_pos_y <= upd_y_fwd;
                    end
                end
                S_RNDY: r_pos_y <= upd_y_asp;
                default: ;
            endcase
        end
    end

    // datapath working registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        unique case (r_state)
            S_IDLE: begin
                if (cmd_take) begin
                    r_op <= t_op'(i_cmd.op);
                    r_a  <= i_cmd.value_a;
                    r_b  <= i_cmd.value_b;
                end
            end
            S_DECODE: begin
                r_rem <= dec_sum;
                r_neg <= dec_sum[SUM_W-1];
                r_cnt <= CNT_W'(MOD_STEPS - 1);
                r_h   <= dec_hnorm;
                r_dy0 <= MA_W'(r_b);
            end
            S_MOD: begin
                r_rem <= mod_next;
                r_cnt <= r_cnt - CNT_W'(1);
            end
            S_QUAD: begin
                r_q   <= quad_q;
                r_z   <= Z_W'(quad_z);
                r_cx  <= CX_W'(CORDIC_K);
                r_cy  <= '0;
                r_cnt <= '0;
            end
            S_ROT: begin
                r_cx  <= rot_x;
                r_cy  <= rot_y;
                r_z   <= rot_z;
                r_cnt <= r_cnt + CNT_W'(1);
            end
            S_MULC: r_dx  <= rnd_q;
            S_RNDC: r_dy0 <= MA_W'(rnd_q);
            default: ;
        endcase
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_out_kind <= fin_kind;
            r_out_col  <= sat_scr(scr_col);
            r_out_row  <= sat_scr(scr_row);
            r_out_x    <= r_pos_x;
            r_out_y    <= r_pos_y;
            r_out_hdg  <= HDG_W'(r_heading);
            r_out_pen  <= r_pen;
        end
    end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// tb_top: self-checking bench for turtle_position_heading_engine_unit, with a bit-exact
// turtle predictor, random idling on both channels and register setup over the apb port
// depends on tphe_pkg, tphe_if.sv and the engine top level
module tb_top;
    import tphe_pkg::*;

    localparam int TB_FRAC_BITS    = 8;
    localparam int TB_CORDIC_STEPS = 16;

    // one full turn in heading units, and the same in cordic degree units
    localparam longint FULL_TURN   = longint'(360) << TB_FRAC_BITS;
    localparam longint TURN_DEG16  = longint'(360) * DEG16;

    // op codes with no command behind them
    localparam logic [OP_W-1:0] OP_SPARE_FIRST = 4'd10;
    localparam logic [OP_W-1:0] OP_SPARE_LAST  = 4'd15;

    localparam logic signed [VAL_W-1:0] VAL_MAX = 24'sh7FFFFF;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 24'sh800000;

    // what the engine reports after one command
    typedef struct {
        t_draw_kind                kind;
        logic signed [SCR_W-1:0]   col;
        logic signed [SCR_W-1:0]   row;
        logic signed [POS_W-1:0]   x;
        logic signed [POS_W-1:0]   y;
        logic signed [HDG_W-1:0]   hdg;
        logic                      pen;
    } t_turtle_view;

    logic clk = 1'b0;
    logic rst_n;

    // apb side
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    tphe_cmd_if cmd_ch();
    tphe_res_if res_ch();

    turtle_position_heading_engine_unit #(
        .CORDIC_STEPS (TB_CORDIC_STEPS),
        .FRAC_BITS    (TB_FRAC_BITS)
    ) u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cmd   (cmd_ch),
        .o_res   (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 0;
    end

    // predicted turtle state
    longint x_now;
    longint y_now;
    longint hdg_now;
    bit     pen_now;

    // mirror of the configuration registers
    logic [ORG_W-1:0] cfg_origin_col;
    logic [ORG_W-1:0] cfg_origin_row;
    logic             cfg_scrunch;
    logic [ASP_W-1:0] cfg_aspect;

    // views predicted for accepted commands, oldest first
    t_turtle_view turtle_views_due[$];

    int fail_count    = 0;
    bit quiet_links   = 1'b0;   // no idling on either channel while set
    int rx_hold_cycles = 0;     // one long receiver hold-off, picked up by the receiver

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // rounds v / 2^s to nearest, halves away from zero
    function automatic longint round_off(input longint v, input int s);
        longint m;
        m = (v < 0) ? -v : v;
        m = (m + (longint'(1) << (s - 1))) >>> s;
        return (v < 0) ? -m : m;
    endfunction

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // vertical scaling by the aspect ratio when scrunch is on
    function automatic longint aspect_scale(input longint v);
        if (cfg_scrunch)
            return round_off(v * longint'(cfg_aspect), ASP_SHIFT);
        return v;
    endfunction

    // arctangent of 2^-i in degrees q.16
    function automatic longint arc_step_q16(input int i);
        case (i)
            0:  return 2949120;
            1:  return 1740967;
            2:  return 919879;
            3:  return 466945;
            4:  return 234379;
            5:  return 117304;
            6:  return 58666;
            7:  return 29335;
            8:  return 14668;
            9:  return 7334;
            10: return 3667;
            11: return 1833;
            12: return 917;
            13: return 458;
            14: return 229;
            15: return 115;
            default: return 0;
        endcase
    endfunction

    // sine and cosine of a heading, q.30, by quadrant fold plus cordic rotation
    function automatic void heading_trig(input longint hdg, output longint sn, output longint cs);
        longint h, q, z, vx, vy, nx;
        int     i;
        h = hdg * (longint'(1) << (16 - TB_FRAC_BITS));
        h = h % TURN_DEG16;
        if (h < 0)
            h = h + TURN_DEG16;
        q  = (h + longint'(45) * DEG16) / (longint'(90) * DEG16);
        z  = h - q * 90 * DEG16;
        vx = CORDIC_K;
        vy = 0;
        for (i = 0; i < TB_CORDIC_STEPS; i++) begin
            if (z >= 0) begin
                nx = vx - (vy >>> i);
                vy = vy + (vx >>> i);
                z  = z - arc_step_q16(i);
            end else begin
                nx = vx + (vy >>> i);
                vy = vy - (vx >>> i);
                z  = z + arc_step_q16(i);
            end
            vx = nx;
        end
        case (q[1:0])
            2'd0: begin sn = vy;  cs = vx;  end
            2'd1: begin sn = vx;  cs = -vy; end
            2'd2: begin sn = -vy; cs = -vx; end
            default: begin sn = -vx; cs = vy; end
        endcase
    endfunction

    // applies one command to the predicted state and returns the view that follows
    function automatic t_turtle_view advance_turtle(input logic [OP_W-1:0] op,
                                                    input logic signed [VAL_W-1:0] va,
                                                    input logic signed [VAL_W-1:0] vb);
        longint       a, b, sn, cs, col, row;
        t_turtle_view v;
        t_draw_kind   kind;
        a    = va;
        b    = vb;
        kind = KIND_NONE;
        case (op)
            OP_FWD: begin
                heading_trig(hdg_now, sn, cs);
                x_now = clamp(x_now + round_off(a * sn, TRIG_SHIFT), POS_MIN, POS_MAX);
                y_now = clamp(y_now + aspect_scale(round_off(a * cs, TRIG_SHIFT)),
                              POS_MIN, POS_MAX);
                kind  = pen_now ? KIND_LINE : KIND_MOVE;
            end
            OP_RIGHT:  hdg_now = (hdg_now + a) % FULL_TURN;
            OP_LEFT:   hdg_now = (hdg_now - a) % FULL_TURN;
            OP_SETHDG: hdg_now = a % FULL_TURN;
            OP_SETPOS: begin
                x_now = a;
                y_now = clamp(aspect_scale(b), POS_MIN, POS_MAX);
                kind  = KIND_MOVE;
            end
            OP_SETX: begin
                x_now = a;
                kind  = KIND_MOVE;
            end
            OP_SETY: begin
                y_now = clamp(aspect_scale(b), POS_MIN, POS_MAX);
                kind  = KIND_MOVE;
            end
            OP_HOME: begin
                x_now   = 0;
                y_now   = 0;
                hdg_now = 0;
                pen_now = 1'b1;
                kind    = KIND_MOVE;
            end
            OP_PENUP:   pen_now = 1'b0;
            OP_PENDOWN: pen_now = 1'b1;
            default: ;
        endcase
        col = clamp(longint'(cfg_origin_col) + round_off(x_now, TB_FRAC_BITS), SCR_MIN, SCR_MAX);
        row = clamp(longint'(cfg_origin_row) - round_off(y_now, TB_FRAC_BITS), SCR_MIN, SCR_MAX);
        v.kind = kind;
        v.col  = SCR_W'(col);
        v.row  = SCR_W'(row);
        v.x    = POS_W'(x_now);
        v.y    = POS_W'(y_now);
        v.hdg  = HDG_W'(hdg_now);
        v.pen  = pen_now;
        return v;
    endfunction

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------

    function automatic void check_field(input string name, input logic signed [31:0] want,
                                        input logic signed [31:0] got);
        if (got !== want) begin
            $error("%s expected %0d got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // compares the result transaction on the channel with the oldest prediction
    function automatic void check_turtle_view();
        t_turtle_view want;
        if (turtle_views_due.size() == 0) begin
            $error("result transaction with no command pending");
            fail_count++;
            return;
        end
        want = turtle_views_due.pop_front();
        check_field("draw_kind",   want.kind, res_ch.draw_kind);
        check_field("screen_col",  want.col,  res_ch.screen_col);
        check_field("screen_row",  want.row,  res_ch.screen_row);
        check_field("pos_x",       want.x,    res_ch.pos_x);
        check_field("pos_y",       want.y,    res_ch.pos_y);
        check_field("heading_deg", want.hdg,  res_ch.heading_deg);
        check_field("pen_is_down", want.pen,  res_ch.pen_is_down);
    endfunction

    // receiver: random stall before each result, or one long hold-off on request
    initial begin
        int stall;
        res_ch.ready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever begin
            if (rx_hold_cycles > 0) begin
                stall          = rx_hold_cycles;
                rx_hold_cycles = 0;
            end else begin
                stall = quiet_links ? 0 : $urandom_range(0, 11);
            end
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            // ready stays up from the previous transaction when there is no stall
            res_ch.ready <= 1'b1;
            do @(posedge clk); while (!res_ch.valid);
            check_turtle_view();
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // offers one command after a random gap and predicts it once it is taken
    task automatic send_command(input logic [OP_W-1:0] op, input logic signed [VAL_W-1:0] va,
                                input logic signed [VAL_W-1:0] vb);
        int gap;
        gap = quiet_links ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid   <= 1'b1;
        cmd_ch.op      <= op;
        cmd_ch.value_a <= va;
        cmd_ch.value_b <= vb;
        do @(posedge clk); while (!cmd_ch.ready);
        turtle_views_due.push_back(advance_turtle(op, va, vb));
    endtask

    // stops offering and waits until every predicted view has come back
    task automatic drain_results();
        cmd_ch.valid <= 1'b0;
        while (turtle_views_due.size() != 0)
            @(posedge clk);
    endtask

    // one apb write, with the bus left idle after it
    task automatic reg_write(input t_reg_idx idx, input logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'({idx, 2'b00});
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_ORIGIN_COL: cfg_origin_col = data[ORG_W-1:0];
            REG_ORIGIN_ROW: cfg_origin_row = data[ORG_W-1:0];
            REG_SCRUNCH:    cfg_scrunch    = data[0];
            REG_ASPECT:     cfg_aspect     = data[ASP_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // one apb read checked against the mirror, with the bus left idle after it
    task automatic reg_read_check(input t_reg_idx idx);
        logic [APB_DW-1:0] got, want, mask;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= APB_AW'({idx, 2'b00});
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        got      = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_ORIGIN_COL: begin want = cfg_origin_col; mask = (1 << ORG_W) - 1; end
            REG_ORIGIN_ROW: begin want = cfg_origin_row; mask = (1 << ORG_W) - 1; end
            REG_SCRUNCH:    begin want = cfg_scrunch;    mask = 1;                end
            default:        begin want = cfg_aspect;     mask = (1 << ASP_W) - 1; end
        endcase
        if ((got & mask) !== want) begin
            $error("%s expected %0d got %0d", idx.name(), want, got & mask);
            fail_count++;
        end
        @(posedge clk);
    endtask

    task automatic write_all_regs(input logic [ORG_W-1:0] col, input logic [ORG_W-1:0] row,
                                  input logic scr, input logic [ASP_W-1:0] asp);
        reg_write(REG_ORIGIN_COL, APB_DW'(col));
        reg_write(REG_ORIGIN_ROW, APB_DW'(row));
        reg_write(REG_SCRUNCH,    APB_DW'(scr));
        reg_write(REG_ASPECT,     APB_DW'(asp));
    endtask

    // mostly modest values so walks stay on screen, sometimes any 24 bit pattern
    function automatic logic signed [VAL_W-1:0] pick_value(input int span);
        if ($urandom_range(0, 3) == 0)
            return VAL_W'($urandom);
        return VAL_W'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    // random command mix weighted toward forward moves, spare codes now and then
    task automatic send_random_command();
        int                       sel;
        logic [OP_W-1:0]          op;
        logic signed [VAL_W-1:0]  va, vb;
        sel = $urandom_range(0, 99);
        va  = pick_value(720 << TB_FRAC_BITS);
        vb  = pick_value(1000 << TB_FRAC_BITS);
        if (sel < 35) begin
            op = OP_FWD;
            va = pick_value(200 << TB_FRAC_BITS);
        end else if (sel < 45) op = OP_RIGHT;
        else if (sel < 53) op = OP_LEFT;
        else if (sel < 60) op = OP_SETHDG;
        else if (sel < 67) begin
            op = OP_SETPOS;
            va = pick_value(1000 << TB_FRAC_BITS);
        end else if (sel < 72) begin
            op = OP_SETX;
            va = pick_value(1000 << TB_FRAC_BITS);
        end else if (sel < 77) op = OP_SETY;
        else if (sel < 81) op = OP_HOME;
        else if (sel < 88) op = OP_PENUP;
        else if (sel < 95) op = OP_PENDOWN;
        else op = OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
        send_command(op, va, vb);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset values read back, then every register written and read again
    task automatic test_register_access();
        reg_read_check(REG_ORIGIN_COL);
        reg_read_check(REG_ORIGIN_ROW);
        reg_read_check(REG_SCRUNCH);
        reg_read_check(REG_ASPECT);
        write_all_regs(12'd320, 12'd240, 1'b1, 16'd12288);
        reg_read_check(REG_ORIGIN_COL);
        reg_read_check(REG_ORIGIN_ROW);
        reg_read_check(REG_SCRUNCH);
        reg_read_check(REG_ASPECT);
    endtask

    // every op, field extremes, heading wrap, saturation and half-pixel rounding
    task automatic test_directed_commands();
        send_command(OP_FWD,     24'sd25600,   24'sd0);         // 100 px north, pen down
        send_command(OP_RIGHT,   24'sd23040,   24'sd0);         // 90 deg
        send_command(OP_FWD,     24'sd12928,   24'sd0);         // 50.5 px east
        send_command(OP_LEFT,    24'sd11520,   24'sd0);         // 45 deg back
        send_command(OP_SETHDG,  -24'sd115200, 24'sd0);         // -450 deg keeps its sign
        send_command(OP_RIGHT,   VAL_MAX,      VAL_MAX);
        send_command(OP_LEFT,    VAL_MIN,      VAL_MIN);
        send_command(OP_SETHDG,  24'sd92159,   24'sd0);         // just under a full turn
        send_command(OP_FWD,     VAL_MAX,      24'sd0);         // position saturates
        send_command(OP_FWD,     VAL_MIN,      24'sd0);
        send_command(OP_PENUP,   24'sd0,       24'sd0);
        send_command(OP_FWD,     24'sd256000,  24'sd0);         // pen up move
        send_command(OP_SETPOS,  VAL_MAX,      VAL_MIN);        // screen saturates
        send_command(OP_SETX,    VAL_MIN,      VAL_MAX);
        send_command(OP_SETY,    24'sd0,       VAL_MAX);        // scaled y
        send_command(OP_HOME,    VAL_MAX,      VAL_MIN);
        send_command(OP_SETHDG,  24'sd34560,   24'sd0);         // 135 deg
        send_command(OP_FWD,     24'sd128,     24'sd0);         // half a pixel
        send_command(OP_SETPOS,  24'sd128,     -24'sd128);      // rounding away from zero
        send_command(OP_PENUP,   24'sd0,       24'sd0);
        send_command(OP_PENDOWN, 24'sd0,       24'sd0);
        send_command(OP_SPARE_FIRST, VAL_MAX,  VAL_MAX);        // spare codes change nothing
        send_command(OP_SPARE_LAST,  VAL_MIN,  VAL_MIN);
        send_command(OP_SETHDG,  24'sd11520,   24'sd0);         // octant boundary
        send_command(OP_FWD,     24'sd2560,    24'sd0);
    endtask

    // register settings including the extremes, random commands under each
    task automatic test_config_sweep();
        logic [ORG_W-1:0] col, row;
        logic             scr;
        logic [ASP_W-1:0] asp;
        int               k, n;
        for (k = 0; k < 8; k++) begin
            case (k)
                0: {col, row, scr, asp} = {12'd0,    12'd0,    1'b1, 16'd16384};
                1: {col, row, scr, asp} = {12'd4095, 12'd4095, 1'b0, 16'd16384};
                2: {col, row, scr, asp} = {12'd320,  12'd240,  1'b1, 16'd0};
                3: {col, row, scr, asp} = {12'd4095, 12'd0,    1'b1, 16'd65535};
                4: {col, row, scr, asp} = {12'd0,    12'd4095, 1'b1, 16'd12288};
                5: {col, row, scr, asp} = {12'd2048, 12'd1024, 1'b0, 16'd65535};
                6: {col, row, scr, asp} = {12'd100,  12'd3000, 1'b1, 16'd20000};
                default: {col, row, scr, asp} = {12'd640, 12'd480, 1'b1, 16'd32768};
            endcase
            // registers change only with nothing in flight
            drain_results();
            write_all_regs(col, row, scr, asp);
            quiet_links = (k % 3 == 2);
            for (n = 0; n < 160; n++)
                send_random_command();
        end
        quiet_links = 1'b0;
    endtask

    // long random walk, idling switched off for every other stretch
    task automatic test_random_walks();
        int chunk, n;
        for (chunk = 0; chunk < 4; chunk++) begin
            quiet_links = chunk[0];
            for (n = 0; n < 125; n++)
                send_random_command();
        end
        quiet_links = 1'b0;
    endtask

    // receiver holds off a long while, sender keeps offering until the input stalls
    task automatic test_receiver_backpressure();
        int n;
        quiet_links    = 1'b1;
        rx_hold_cycles = 400;
        for (n = 0; n < 80; n++)
            send_random_command();
        quiet_links = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        x_now          = 0;
        y_now          = 0;
        hdg_now        = 0;
        pen_now        = 1'b1;
        cfg_origin_col = '0;
        cfg_origin_row = '0;
        cfg_scrunch    = 1'b1;
        cfg_aspect     = 16'd16384;

        rst_n          <= 1'b0;
        cmd_ch.valid   <= 1'b0;
        cmd_ch.op      <= OP_FWD;
        cmd_ch.value_a <= '0;
        cmd_ch.value_b <= '0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_register_access();
        test_directed_commands();
        test_config_sweep();
        test_random_walks();
        test_receiver_backpressure();

        // everything back, then a quiet spell to catch stray results
        drain_results();
        repeat (40) @(posedge clk);
        if (fail_count == 0) begin
            $display("turtle_position_heading_engine_unit verification clean");
        end else begin
            $display("turtle_position_heading_engine_unit verification failed");
        end
        $finish;
    end

    // hang guard, far beyond the slowest correct run
    initial begin
        #5000000;
        $display("turtle_position_heading_engine_unit verification failed");
        $finish;
    end

endmodule
